// ----- hw/rtl/fclq_pkg.sv -----
// Shared types and codes of the fault code log queue.
// No dependencies; imported by fclq_slot_unit and fault_code_log_queue_unit.
`default_nettype none
package fclq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 3;
   localparam int STAMP_W       = 32;
   localparam int CODE_W        = 16;
   localparam int SLOT_W        = 8;
   localparam int COUNT_W       = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_NEW_CODE   = 3'd0,
      CMD_PUSH       = 3'd1,
      CMD_DEQUEUE    = 3'd2,
      CMD_RESET_ALL  = 3'd3,
      CMD_READ_FRONT = 3'd4,
      CMD_READ_ENTRY = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_DROPPED_OLDEST = 3'd1,
      ST_ALREADY        = 3'd2,
      ST_FULL           = 3'd3,
      ST_EMPTY          = 3'd4,
      ST_BAD_INDEX      = 3'd5
   } status_type;

   // One stored log entry, as kept in the slot memory
   typedef struct packed {
      logic               cleared;
      logic [CODE_W-1:0]  code;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result of one step of the slot unit
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] next_slot;
   } step_type;

endpackage
`default_nettype wire

// ----- hw/rtl/fclq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fclq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/fclq_slot_unit.sv -----
// Shared slot step unit: circular slot advance and active-code compare.
// Depends on fclq_pkg.
`default_nettype none
module fclq_slot_unit #(
   parameter int DEPTH = fclq_pkg::DEFAULT_DEPTH
) (
   input  wire logic [$clog2(DEPTH)-1:0] slot,
   input  wire fclq_pkg::entry_type      entry,
   input  wire logic [fclq_pkg::CODE_W-1:0] key,
   output fclq_pkg::step_type            result
);
   import fclq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W:0]   inc;
   logic [IDX_W-1:0] next;

   always_comb begin
      inc  = {1'b0, slot} + (IDX_W+1)'(1);
      // wrap to slot zero past the last slot
      next = (inc >= (IDX_W+1)'(DEPTH)) ? '0 : inc[IDX_W-1:0];
      result.next_slot = SLOT_W'(next);
      result.hit       = !entry.cleared && (entry.code == key);
   end

endmodule
`default_nettype wire

// ----- hw/rtl/fault_code_log_queue_unit.sv -----
// Fault code log queue: circular store of (time, code, cleared) entries.
// Requests enter on req_*, one response per request leaves on rsp_*.
// A request is taken when req_valid is high and req_stall low; req_stall
// stays high while a request is being worked on. The response is held in
// an output register until rsp_valid is high with rsp_stall low.
// Work per request, with n the held entry count (up to DEPTH):
//   new_code, reset_all : scan of all n held entries, then finish
//     (a duplicate code ends the new_code scan early)
//   dequeue, read_front, read_entry : one slot read, then finish
//   push, unknown, bad-index or empty-queue cases : finish only
// The slot scan issues one slot memory read per cycle, stepped through
// the shared slot unit, then judges the last read and finishes. The
// response register loads at the edge that returns the block to ready;
// a stalled response holds the next request in its final step until
// the register frees.
// Reset (synchronous) empties the queue and makes every slot read as zero;
// per-slot written bits clear at once, so no clearing pass is needed.
// Depends on fclq_pkg, fclq_ram and fclq_slot_unit.
`default_nettype none
module fault_code_log_queue_unit #(
   parameter int DEPTH = fclq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [fclq_pkg::CMD_W-1:0]     req_command,
   input  wire logic [fclq_pkg::STAMP_W-1:0]   req_time_stamp,
   input  wire logic [fclq_pkg::CODE_W-1:0]    req_fault_code,
   input  wire logic [fclq_pkg::SLOT_W-1:0]    req_slot_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [fclq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [fclq_pkg::STAMP_W-1:0]   rsp_out_time,
   output logic      [fclq_pkg::CODE_W-1:0]    rsp_out_code,
   output logic                                rsp_out_reset,
   output logic      [fclq_pkg::COUNT_W-1:0]   rsp_held_count,
   output logic      [fclq_pkg::COUNT_W-1:0]   rsp_active_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full
);
   import fclq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      FINISH
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] active_ff, active_in;
   logic [DEPTH-1:0] written_ff, written_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;
   logic             first_ff, first_in;
   logic             live_ff, live_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   cmd_type          cmd_ff, cmd_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic             head_clr_ff, head_clr_in;
   entry_type        rd_entry_ff, rd_entry_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0] rsp_held_ff, rsp_held_in;
   logic [CNT_W-1:0] rsp_active_ff, rsp_active_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_full_ff, rsp_full_in;

   // memory and unit connections
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type        entry;
   logic [IDX_W-1:0] unit_slot;
   step_type         unit_res;
   logic [IDX_W-1:0] unit_next;

   logic             full, empty, out_free, adv_head, bad_idx_req, bad_idx;
   logic [IDX_W-1:0] app_slot;

   fclq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fclq_slot_unit #(
      .DEPTH (DEPTH)
   ) u_step (
      .slot   (unit_slot),
      .entry  (entry),
      .key    (code_ff),
      .result (unit_res)
   );

   assign entry     = live_ff ? entry_type'(ram_rd_data) : '0;
   assign unit_next = unit_res.next_slot[IDX_W-1:0];

   always_comb begin
      full        = (occ_ff == CNT_W'(DEPTH));
      empty       = (occ_ff == '0);
      out_free    = !rsp_valid_ff || !rsp_stall;
      adv_head    = (cmd_ff == CMD_DEQUEUE) || ((cmd_ff == CMD_NEW_CODE) && full);
      bad_idx_req = ({1'b0, req_slot_index} >= (SLOT_W+1)'(DEPTH));
      bad_idx     = ({1'b0, idx_ff} >= (SLOT_W+1)'(DEPTH));
      unit_slot   = (state_ff == SCAN) ? scan_ptr_ff : (adv_head ? head_ff : tail_ff);
      // append slot: slot zero on an empty queue, else one past the tail
      app_slot    = empty ? '0 : unit_next;

      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      active_in     = active_ff;
      written_in    = written_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd_in        = cmd_ff;
      stamp_in      = stamp_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      scan_ptr_in   = scan_ptr_ff;
      pend_slot_in  = pend_slot_ff;
      head_clr_in   = head_clr_ff;
      rd_entry_in   = rd_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_active_in = rsp_active_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_slot_ff;
      ram_wr_data = '{cleared: 1'b1, code: entry.code, stamp: entry.stamp};
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ptr_ff;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd_in      = cmd_type'(req_command);
               stamp_in    = req_time_stamp;
               code_in     = req_fault_code;
               idx_in      = req_slot_index;
               pend_in     = 1'b0;
               found_in    = 1'b0;
               first_in    = 1'b0;
               scan_ptr_in = head_ff;
               left_in     = CNT_W'(1);
               state_in    = FINISH;
               case (cmd_type'(req_command))
                  CMD_NEW_CODE, CMD_RESET_ALL: begin
                     left_in = occ_ff;
                     if (!empty) state_in = SCAN;
                  end
                  CMD_DEQUEUE, CMD_READ_FRONT: begin
                     if (!empty) state_in = SCAN;
                  end
                  CMD_READ_ENTRY: begin
                     scan_ptr_in = req_slot_index[IDX_W-1:0];
                     if (!bad_idx_req) state_in = SCAN;
                  end
                  default: begin
                     state_in = FINISH;
                  end
               endcase
            end
         end

         SCAN: begin
            // issue one slot read per cycle, judge it the next cycle
            if (left_ff != '0) begin
               ram_rd_en    = 1'b1;
               live_in      = written_ff[scan_ptr_ff];
               scan_ptr_in  = unit_next;
               left_in      = left_ff - CNT_W'(1);
               pend_in      = 1'b1;
               pend_slot_in = scan_ptr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (!first_ff) begin
                  first_in    = 1'b1;
                  head_clr_in = entry.cleared;
                  rd_entry_in = entry;
               end
               if ((cmd_ff == CMD_NEW_CODE) && unit_res.hit) begin
                  found_in = 1'b1;
               end
               if (cmd_ff == CMD_RESET_ALL) begin
                  ram_wr_en = 1'b1;
               end
            end
            if ((left_ff == '0) ||
                (pend_ff && (cmd_ff == CMD_NEW_CODE) && unit_res.hit)) begin
               state_in = FINISH;
            end
         end

         FINISH: begin
            if (out_free) begin
               rsp_status_in = ST_OK;
               rsp_entry_in  = '0;
               ram_wr_data   = '{cleared: 1'b0, code: code_ff, stamp: stamp_ff};
               case (cmd_ff)
                  CMD_NEW_CODE: begin
                     if (found_ff) begin
                        rsp_status_in = ST_ALREADY;
                     end else if (full) begin
                        // drop oldest; its slot takes the new entry
                        rsp_status_in = ST_DROPPED_OLDEST;
                        head_in       = unit_next;
                        tail_in       = head_ff;
                        active_in     = active_ff - CNT_W'(!head_clr_ff) + CNT_W'(1);
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = head_ff;
                        written_in[head_ff] = 1'b1;
                     end else begin
                        if (empty) head_in = '0;
                        tail_in     = app_slot;
                        occ_in      = occ_ff + CNT_W'(1);
                        active_in   = active_ff + CNT_W'(1);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = app_slot;
                        written_in[app_slot] = 1'b1;
                     end
                  end
                  CMD_PUSH: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        if (empty) head_in = '0;
                        tail_in     = app_slot;
                        occ_in      = occ_ff + CNT_W'(1);
                        active_in   = active_ff + CNT_W'(1);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = app_slot;
                        written_in[app_slot] = 1'b1;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        occ_in    = occ_ff - CNT_W'(1);
                        active_in = active_ff - CNT_W'(!head_clr_ff);
                        if (occ_ff == CNT_W'(1)) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           head_in = unit_next;
                        end
                     end
                  end
                  CMD_RESET_ALL: begin
                     active_in = '0;
                  end
                  CMD_READ_FRONT: begin
                     if (empty) rsp_status_in = ST_EMPTY;
                     else       rsp_entry_in  = rd_entry_ff;
                  end
                  CMD_READ_ENTRY: begin
                     if (bad_idx) rsp_status_in = ST_BAD_INDEX;
                     else         rsp_entry_in  = rd_entry_ff;
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
               rsp_held_in   = occ_in;
               rsp_active_in = active_in;
               rsp_empty_in  = (occ_in == '0);
               rsp_full_in   = (occ_in == CNT_W'(DEPTH));
               rsp_valid_in  = 1'b1;
               state_in      = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         active_ff    <= '0;
         written_ff   <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         first_ff     <= 1'b0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         active_ff    <= active_in;
         written_ff   <= written_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         first_ff     <= first_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      stamp_ff      <= stamp_in;
      code_ff       <= code_in;
      idx_ff        <= idx_in;
      scan_ptr_ff   <= scan_ptr_in;
      pend_slot_ff  <= pend_slot_in;
      head_clr_ff   <= head_clr_in;
      rd_entry_ff   <= rd_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_active_ff <= rsp_active_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign req_stall        = (state_ff != IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_time     = rsp_entry_ff.stamp;
   assign rsp_out_code     = rsp_entry_ff.code;
   assign rsp_out_reset    = rsp_entry_ff.cleared;
   assign rsp_held_count   = COUNT_W'(rsp_held_ff);
   assign rsp_active_count = COUNT_W'(rsp_active_ff);
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;

endmodule
`default_nettype wire
